>>> rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    // default component width, code 2^bits-1 is full intensity
    localparam int COMP_BITS_DEF = 16;

    // entries of the queue between classifier and divider pipeline
    localparam int QUEUE_DEPTH = 2;

    // special-case marks that travel with a pixel
    typedef struct packed {
        logic black;   // value is zero, saturation forced to zero
        logic grey;    // chroma is zero, hue forced to zero
    } t_flags;

endpackage

>>> rtl/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// RGB to HSV converter: classifier, short queue, pipelined bit-serial dividers.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one HSV result per clock, sustained, while
// the output is not held. Hue and saturation come from two restoring dividers
// pipelined at one quotient bit per stage; a pixel passes from accepted input
// beat to output beat through the classifier register, one queue entry and
// COMPONENT_BITS divider stages. A held output stalls the divider pipeline;
// the two-entry queue lets the classifier keep accepting meanwhile.
module rgb_to_hsv_pixel #(
    parameter int COMPONENT_BITS = rgbhsv_pkg::COMP_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COMPONENT_BITS-1:0] i_red,
    input  logic [COMPONENT_BITS-1:0] i_green,
    input  logic [COMPONENT_BITS-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [COMPONENT_BITS-1:0] o_hue,
    output logic [COMPONENT_BITS-1:0] o_saturation,
    output logic [COMPONENT_BITS-1:0] o_brightness
);
    import rgbhsv_pkg::*;

    localparam int W  = COMPONENT_BITS;
    localparam int DW = 2 + W + 2 * W + 2 * (W + 3);

    logic           f_v, f_stall, q_v, q_stall;
    logic [W+2:0]   f_hnum, f_hden, q_hnum, q_hden;
    logic [2*W-1:0] f_sat_num, q_sat_num;
    logic [W-1:0]   f_hi, q_hi;
    t_flags         f_flags, q_flags;
    logic [DW-1:0]  q_in, q_out;

    rgbhsv_front #(.W(W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(f_v), .i_stall(f_stall),
        .o_hnum(f_hnum), .o_hden(f_hden), .o_sat_num(f_sat_num),
        .o_hi(f_hi), .o_flags(f_flags)
    );

    assign q_in = {f_flags, f_hi, f_sat_num, f_hnum, f_hden};

    rgbhsv_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_v), .o_stall(f_stall), .i_data(q_in),
        .o_valid(q_v), .i_stall(q_stall), .o_data(q_out)
    );

    assign {q_flags, q_hi, q_sat_num, q_hnum, q_hden} = q_out;

    rgbhsv_back #(.W(W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_v), .o_stall(q_stall),
        .i_hnum(q_hnum), .i_hden(q_hden), .i_sat_num(q_sat_num),
        .i_hi(q_hi), .i_flags(q_flags),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hue(o_hue), .o_saturation(o_saturation), .o_brightness(o_brightness)
    );

endmodule

>>> rtl/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Accepts pixels, finds max/min/chroma and the hue sector, and forms the
// numerators and divisors for the hue and saturation divisions.
// ----------------------------------------------------------------------------
module rgbhsv_front #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [W-1:0]          i_red,
    input  logic [W-1:0]          i_green,
    input  logic [W-1:0]          i_blue,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [W+2:0]          o_hnum,
    output logic [W+2:0]          o_hden,
    output logic [2*W-1:0]        o_sat_num,
    output logic [W-1:0]          o_hi,
    output rgbhsv_pkg::t_flags    o_flags
);
    import rgbhsv_pkg::*;

    logic           r_v;
    logic [W+2:0]   r_hnum;
    logic [W+2:0]   r_hden;
    logic [2*W-1:0] r_sat_num;
    logic [W-1:0]   r_hi;
    t_flags         r_flags;

    logic           adv;
    logic [W-1:0]   hi, lo, c;
    logic [W+3:0]   cx, rx, gx, bx, c6, num;
    logic [2*W-1:0] sat_num;

    // classification: max with ties red, green, blue
    always_comb begin
        hi = i_red;
        if (i_green > hi) hi = i_green;
        if (i_blue > hi) hi = i_blue;
        lo = i_red;
        if (i_green < lo) lo = i_green;
        if (i_blue < lo) lo = i_blue;
        c  = hi - lo;
        cx = {4'b0, c};
        rx = {4'b0, i_red};
        gx = {4'b0, i_green};
        bx = {4'b0, i_blue};
        c6 = (cx << 2) + (cx << 1);
        // numerator kept in [0, 6c): red sector with blue above green wraps a turn
        if (hi == i_red) begin
            num = (i_green >= i_blue) ? (gx - bx) : (c6 - (bx - gx));
        end else if (hi == i_green) begin
            num = (cx << 1) + bx - rx;
        end else begin
            num = (cx << 2) + rx - gx;
        end
        // chroma * (2^W - 1)
        sat_num = ({W'(0), c} << W) - {W'(0), c};
    end

    assign adv     = !r_v || !i_stall;
    assign o_stall = r_v && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_hnum        <= num[W+2:0];
            r_hden        <= c6[W+2:0];
            r_sat_num     <= sat_num;
            r_hi          <= hi;
            r_flags.black <= (hi == '0);
            r_flags.grey  <= (c == '0);
        end
    end

    assign o_valid   = r_v;
    assign o_hnum    = r_hnum;
    assign o_hden    = r_hden;
    assign o_sat_num = r_sat_num;
    assign o_hi      = r_hi;
    assign o_flags   = r_flags;

endmodule

>>> rtl/rgbhsv_queue.sv
// ----------------------------------------------------------------------------
// rgbhsv_queue
// Short FIFO between the classifier and the divider pipeline.
// ----------------------------------------------------------------------------
module rgbhsv_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [DW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [DW-1:0] o_data
);
    import rgbhsv_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_stall = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> rtl/rgbhsv_back.sv
// ----------------------------------------------------------------------------
// rgbhsv_back
// Two restoring dividers side by side, one quotient bit per stage, W stages.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module rgbhsv_back #(
    parameter int W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [W+2:0]          i_hnum,
    input  logic [W+2:0]          i_hden,
    input  logic [2*W-1:0]        i_sat_num,
    input  logic [W-1:0]          i_hi,
    input  rgbhsv_pkg::t_flags    i_flags,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [W-1:0]          o_hue,
    output logic [W-1:0]          o_saturation,
    output logic [W-1:0]          o_brightness
);
    import rgbhsv_pkg::*;

    // stage registers
    logic [W-1:0]   r_v;
    logic [W+2:0]   r_hrem [W];
    logic [W+2:0]   r_hden [W];
    logic [W-1:0]   r_hq   [W];
    logic [W-1:0]   r_srem [W];
    logic [W-1:0]   r_slow [W];
    logic [W-1:0]   r_sq   [W];
    logic [W-1:0]   r_hi   [W];
    t_flags         r_fl   [W];

    // stage sources
    logic           s_v    [W];
    logic [W+2:0]   s_hrem [W];
    logic [W+2:0]   s_hden [W];
    logic [W-1:0]   s_hq   [W];
    logic [W-1:0]   s_srem [W];
    logic [W-1:0]   s_slow [W];
    logic [W-1:0]   s_sq   [W];
    logic [W-1:0]   s_hi   [W];
    t_flags         s_fl   [W];

    logic en;

    // whole pipeline moves unless the output beat is held
    assign en      = !r_v[W-1] || !i_stall;
    assign o_stall = !en;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+3:0] h2, hsub;
        logic [W:0]   s2, ssub;
        logic         hge, sge;

        if (k == 0) begin : g_src0
            assign s_v[k]    = i_valid;
            assign s_hrem[k] = i_hnum;
            assign s_hden[k] = i_hden;
            assign s_hq[k]   = '0;
            assign s_srem[k] = i_sat_num[2*W-1:W];
            assign s_slow[k] = i_sat_num[W-1:0];
            assign s_sq[k]   = '0;
            assign s_hi[k]   = i_hi;
            assign s_fl[k]   = i_flags;
        end else begin : g_srcn
            assign s_v[k]    = r_v[k-1];
            assign s_hrem[k] = r_hrem[k-1];
            assign s_hden[k] = r_hden[k-1];
            assign s_hq[k]   = r_hq[k-1];
            assign s_srem[k] = r_srem[k-1];
            assign s_slow[k] = r_slow[k-1];
            assign s_sq[k]   = r_sq[k-1];
            assign s_hi[k]   = r_hi[k-1];
            assign s_fl[k]   = r_fl[k-1];
        end

        // one restoring step of each division
        assign h2   = {s_hrem[k], 1'b0};
        assign hge  = (h2 >= {1'b0, s_hden[k]});
        assign hsub = h2 - {1'b0, s_hden[k]};
        assign s2   = {s_srem[k], s_slow[k][W-1]};
        assign sge  = (s2 >= {1'b0, s_hi[k]});
        assign ssub = s2 - {1'b0, s_hi[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_hrem[k] <= hge ? hsub[W+2:0] : h2[W+2:0];
                r_hden[k] <= s_hden[k];
                r_hq[k]   <= {s_hq[k][W-2:0], hge};
                r_srem[k] <= sge ? ssub[W-1:0] : s2[W-1:0];
                r_slow[k] <= {s_slow[k][W-2:0], 1'b0};
                r_sq[k]   <= {s_sq[k][W-2:0], sge};
                r_hi[k]   <= s_hi[k];
                r_fl[k]   <= s_fl[k];
            end
        end
    end

    // special cases override the quotients
    assign o_valid      = r_v[W-1];
    assign o_hue        = r_fl[W-1].grey  ? '0 : r_hq[W-1];
    assign o_saturation = r_fl[W-1].black ? '0 : r_sq[W-1];
    assign o_brightness = r_hi[W-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline moved while output beat was held");
    a_black_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && r_fl[0].black |-> r_fl[0].grey)
        else $error("black pixel without grey mark");
    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("nonzero saturation at zero value");
`endif

endmodule

>>> tb/sv/rgb_to_hsv_pixel_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// Self-checking bench for the RGB to HSV converter. Pixels are pushed through
// a valid/stall driver with random gaps; each output beat is compared with a
// predicted hue, saturation and value in arrival order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;

    localparam int CB = rgbhsv_pkg::COMP_BITS_DEF;
    localparam logic [CB-1:0] MAXC = {CB{1'b1}};
    localparam int N_RANDOM = 1700;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CB-1:0] hue;
        logic [CB-1:0] sat;
        logic [CB-1:0] val;
    } t_hsv;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    logic [CB-1:0] i_red = '0, i_green = '0, i_blue = '0;
    logic          o_valid;
    logic          i_stall = 1'b1;
    logic [CB-1:0] o_hue, o_saturation, o_brightness;

    t_pixel pixel_q[$];
    t_hsv   hsv_q[$];
    int     n_errors = 0;
    bit     feed_done = 1'b0;

    rgb_to_hsv_pixel #(.COMPONENT_BITS(CB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_hue(o_hue), .o_saturation(o_saturation), .o_brightness(o_brightness)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact integer HSV conversion
    function automatic t_hsv to_hsv(t_pixel p);
        longint r, g, b, hi, lo, chroma, offset, diff, num, den, q;
        t_hsv o;
        r = p.red; g = p.green; b = p.blue;
        hi = r; if (g > hi) hi = g; if (b > hi) hi = b;
        lo = r; if (g < lo) lo = g; if (b < lo) lo = b;
        chroma = hi - lo;
        o.val = hi[CB-1:0];
        o.sat = '0;
        o.hue = '0;
        if (hi != 0) begin
            q = (chroma * longint'(MAXC)) / hi;
            o.sat = q[CB-1:0];
        end
        if (chroma != 0) begin
            // ties go to red, then green
            if (hi == r) begin
                offset = 0; diff = g - b;
            end else if (hi == g) begin
                offset = 2; diff = b - r;
            end else begin
                offset = 4; diff = r - g;
            end
            num = (offset * chroma + diff) <<< CB;
            den = 6 * chroma;
            // floor division, negative red-sector hues wrap below a full turn
            if (num >= 0) q = num / den;
            else q = -((-num + den - 1) / den);
            o.hue = q[CB-1:0];
        end
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [CB-1:0] rand_comp();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return MAXC;
        return CB'($urandom_range(0, int'(MAXC)));
    endfunction

    // stimulus: directed corners, then random pixels
    initial begin
        t_pixel p;
        int k;
        pixel_q.push_back('{'0, '0, '0});            // black
        pixel_q.push_back('{MAXC, MAXC, MAXC});      // white
        pixel_q.push_back('{16'h8000, 16'h8000, 16'h8000}); // grey
        pixel_q.push_back('{MAXC, '0, '0});
        pixel_q.push_back('{'0, MAXC, '0});
        pixel_q.push_back('{'0, '0, MAXC});
        pixel_q.push_back('{MAXC, MAXC, '0});        // red/green tie
        pixel_q.push_back('{'0, MAXC, MAXC});        // green/blue tie
        pixel_q.push_back('{MAXC, '0, MAXC});        // red/blue tie
        pixel_q.push_back('{MAXC, '0, 16'h0001});    // red sector, wraps
        pixel_q.push_back('{MAXC, 16'h0001, '0});
        pixel_q.push_back('{16'h0001, '0, '0});      // tiny chroma
        pixel_q.push_back('{16'h0001, '0, 16'h0001});
        pixel_q.push_back('{16'h1234, MAXC, 16'hFFFE});
        pixel_q.push_back('{16'h5555, 16'hAAAA, MAXC});
        pixel_q.push_back('{16'hFFFE, MAXC, 16'hFFFE});
        for (int i = 0; i < N_RANDOM; i++) begin
            p = '{rand_comp(), rand_comp(), rand_comp()};
            k = $urandom_range(0, 9);
            if (k == 0) p.green = p.red;                // forced ties
            else if (k == 1) p.blue = p.green;
            pixel_q.push_back(p);
        end
        feed_done = 1'b1;
    end

    // reset
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stall value seen at the last rising edge
    logic o_stall_s = 1'b1;
    always @(posedge i_clk) o_stall_s <= o_stall | ~i_valid;

    // driver: applies at falling edge, beat taken at rising edge
    int  drv_gap = 0;
    bit  drv_busy = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (drv_busy && !o_stall_s) begin
                drv_busy = 1'b0;
                drv_gap = gap_len();
            end
            if (!drv_busy) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    t_pixel p;
                    p = pixel_q.pop_front();
                    hsv_q.push_back(to_hsv(p));
                    i_red <= p.red; i_green <= p.green; i_blue <= p.blue;
                    i_valid <= 1'b1;
                    drv_busy = 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b1;
        else if (rx_gap > 0) begin
            rx_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            rx_gap = gap_len();
        end
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsv_q.size() == 0) begin
                $error("unexpected output beat");
                n_errors++;
            end else begin
                t_hsv e;
                e = hsv_q.pop_front();
                if (o_hue !== e.hue) begin
                    $error("hue: expected %h, got %h", e.hue, o_hue);
                    n_errors++;
                end
                if (o_saturation !== e.sat) begin
                    $error("saturation: expected %h, got %h", e.sat, o_saturation);
                    n_errors++;
                end
                if (o_brightness !== e.val) begin
                    $error("brightness: expected %h, got %h", e.val, o_brightness);
                    n_errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (feed_done && i_rst_n);
        wait (pixel_q.size() == 0 && !drv_busy);
        wait (hsv_q.size() == 0);
        repeat (2 * CB + 40) @(posedge i_clk);
        if (n_errors == 0 && hsv_q.size() == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
